// File: rtl/swdh_pkg.sv
// ----------------------------------------------------------------------------
// swdh_pkg
// Shared types and constants of the serial wire debug host packet engine.
// ----------------------------------------------------------------------------
`default_nettype none

package swdh_pkg;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_IDX_W   = 2;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_IDLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_IDLE = 2'd2;

  localparam logic [7:0] RESET_HIGH_DEF = 8'd60;
  localparam logic [7:0] READ_IDLE_DEF  = 8'd3;
  localparam logic [7:0] WRITE_IDLE_DEF = 8'd20;

  localparam logic [7:0] HEADER_BITS = 8'd8;
  localparam logic [7:0] ACK_BITS_N  = 8'd3;
  localparam logic [7:0] DATA_BITS   = 8'd33;
  localparam logic [7:0] RESET_LOW   = 8'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic        swdio_in;
    logic [31:0] write_data;
    logic [1:0]  reg_addr;
    logic        ap_select;
    logic        is_write;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  ack;
    logic        done_res;
    logic        busy_res;
    logic        swdio_drive;
    logic        swdio_out;
    logic        swclk_pulse;
  } out_item_t;

  typedef struct packed {
    logic [7:0] reset_high_clocks;
    logic [7:0] read_idle_clocks;
    logic [7:0] write_idle_clocks;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/swd_host_packet_engine.sv
// ----------------------------------------------------------------------------
// swd_host_packet_engine
// Host side of a serial wire debug link, one SWCLK bit period per item.
// ----------------------------------------------------------------------------
// Each accepted input item is one bit period and yields exactly one result
// item. An item passes an input register, the sequencer step and a result
// register. Its result is presented from the result register once the item
// has left the input register. One item is taken every cycle while the output
// is not stalled, since each step updates the sequencer state.
// Configuration writes are always ready and should be issued only while no
// packet or line reset is in progress.
`default_nettype none

module swd_host_packet_engine (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // is_write, ap_select, reg_addr[1:0], write_data[31:0], swdio_in, zero pad
  input  wire logic [swdh_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command[1:0]
  input  wire logic [1:0]                       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // swclk_pulse, swdio_out, swdio_drive, busy_res, ack[2:0], read_data[31:0],
  // zero pad
  output logic [swdh_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // done_res
  output logic                                  out_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [swdh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [7:0]                       cfg_data
);

  logic                in_vld_r, in_vld_nxt;
  swdh_pkg::in_item_t  in_item_r;
  logic                out_vld_r, out_vld_nxt;
  swdh_pkg::out_item_t out_item_r;
  swdh_pkg::out_item_t res;
  swdh_pkg::cfg_t      cfg_r;
  logic                adv;
  logic                fire;
  logic                in_acc;

  assign adv       = !out_vld_r || out_tready;
  assign fire      = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = adv ? in_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cfg_r     <= '{reset_high_clocks: swdh_pkg::RESET_HIGH_DEF,
                     read_idle_clocks:  swdh_pkg::READ_IDLE_DEF,
                     write_idle_clocks: swdh_pkg::WRITE_IDLE_DEF};
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          swdh_pkg::REG_RESET_HIGH: cfg_r.reset_high_clocks <= cfg_data;
          swdh_pkg::REG_READ_IDLE:  cfg_r.read_idle_clocks  <= cfg_data;
          swdh_pkg::REG_WRITE_IDLE: cfg_r.write_idle_clocks <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r.command    <= in_tuser;
      in_item_r.is_write   <= in_tdata[0];
      in_item_r.ap_select  <= in_tdata[1];
      in_item_r.reg_addr   <= in_tdata[3:2];
      in_item_r.write_data <= in_tdata[35:4];
      in_item_r.swdio_in   <= in_tdata[36];
    end
    if (fire) begin
      out_item_r <= res;
    end
  end

  swdh_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (fire),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_item_r.done_res;
  assign out_tdata  = {1'b0, out_item_r.read_data, out_item_r.ack, out_item_r.busy_res,
                       out_item_r.swdio_drive, out_item_r.swdio_out,
                       out_item_r.swclk_pulse};

endmodule

`default_nettype wire

// File: rtl/swdh_core.sv
// ----------------------------------------------------------------------------
// swdh_core
// Packet and line reset sequencer: one bit period per step.
// ----------------------------------------------------------------------------
`default_nettype none

module swdh_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire swdh_pkg::in_item_t item,
  input  wire swdh_pkg::cfg_t     cfg,
  output swdh_pkg::out_item_t     res
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HEADER,
    PH_TURN1,
    PH_ACK,
    PH_RDATA,
    PH_TURN2,
    PH_WDATA,
    PH_TRAIL,
    PH_RHIGH,
    PH_RLOW
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [32:0] shift_r, shift_nxt;
  logic [2:0]  ack_r, ack_nxt;
  logic [31:0] rx_r, rx_nxt;
  logic        req_wr_r, req_wr_nxt;
  logic [7:0]  hdr_r, hdr_nxt;

  logic        rnw;
  logic        par;
  logic [7:0]  cnt_inc;
  logic [7:0]  trail;
  logic        end_data;
  logic        clk_p, dout, drv, busy, done;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    shift_nxt  = shift_r;
    ack_nxt    = ack_r;
    rx_nxt     = rx_r;
    req_wr_nxt = req_wr_r;
    hdr_nxt    = hdr_r;
    clk_p      = 1'b1;
    dout       = 1'b0;
    drv        = 1'b1;
    busy       = 1'b1;
    done       = 1'b0;
    end_data   = 1'b0;
    rnw        = ~item.is_write;
    par        = item.ap_select ^ rnw ^ item.reg_addr[0] ^ item.reg_addr[1];

    // command taken only while idle, same period starts the sequence
    if (phase_r == PH_IDLE) begin
      case (item.command)
        swdh_pkg::CMD_START: begin
          hdr_nxt    = {1'b1, 1'b0, par, item.reg_addr[1], item.reg_addr[0], rnw,
                        item.ap_select, 1'b1};
          req_wr_nxt = item.is_write;
          shift_nxt  = item.is_write ? {^item.write_data, item.write_data} : 33'd0;
          ack_nxt    = 3'd0;
          cnt_nxt    = 8'd0;
          phase_nxt  = PH_HEADER;
        end
        swdh_pkg::CMD_RESET: begin
          cnt_nxt   = 8'd0;
          phase_nxt = (cfg.reset_high_clocks == 8'd0) ? PH_RLOW : PH_RHIGH;
        end
        default: begin
        end
      endcase
    end

    cnt_inc = cnt_nxt + 8'd1;
    trail   = req_wr_nxt ? cfg.write_idle_clocks : cfg.read_idle_clocks;

    case (phase_nxt)
      PH_HEADER: begin
        dout    = hdr_nxt[cnt_nxt[2:0]];
        cnt_nxt = cnt_inc;
        if (cnt_inc >= swdh_pkg::HEADER_BITS) begin
          phase_nxt = PH_TURN1;
          cnt_nxt   = 8'd0;
        end
      end
      PH_TURN1: begin
        drv       = 1'b0;
        phase_nxt = PH_ACK;
        cnt_nxt   = 8'd0;
      end
      PH_ACK: begin
        drv     = 1'b0;
        ack_nxt = {item.swdio_in, ack_nxt[2:1]};
        cnt_nxt = cnt_inc;
        if (cnt_inc >= swdh_pkg::ACK_BITS_N) begin
          cnt_nxt   = 8'd0;
          phase_nxt = req_wr_nxt ? PH_TURN2 : PH_RDATA;
        end
      end
      PH_RDATA: begin
        drv       = 1'b0;
        shift_nxt = {item.swdio_in, shift_nxt[32:1]};
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= swdh_pkg::DATA_BITS) begin
          rx_nxt   = shift_nxt[31:0];
          end_data = 1'b1;
        end
      end
      PH_TURN2: begin
        drv       = 1'b0;
        phase_nxt = PH_WDATA;
        cnt_nxt   = 8'd0;
      end
      PH_WDATA: begin
        dout      = shift_nxt[0];
        shift_nxt = {1'b0, shift_nxt[32:1]};
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= swdh_pkg::DATA_BITS) begin
          end_data = 1'b1;
        end
      end
      PH_TRAIL: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= trail) begin
          done      = 1'b1;
          phase_nxt = PH_IDLE;
          cnt_nxt   = 8'd0;
        end
      end
      PH_RHIGH: begin
        dout    = 1'b1;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= cfg.reset_high_clocks) begin
          phase_nxt = PH_RLOW;
          cnt_nxt   = 8'd0;
        end
      end
      PH_RLOW: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= swdh_pkg::RESET_LOW) begin
          done      = 1'b1;
          phase_nxt = PH_IDLE;
          cnt_nxt   = 8'd0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        clk_p     = 1'b0;
        busy      = 1'b0;
        cnt_nxt   = 8'd0;
      end
    endcase

    if (end_data) begin
      cnt_nxt = 8'd0;
      if (trail == 8'd0) begin
        done      = 1'b1;
        phase_nxt = PH_IDLE;
      end else begin
        phase_nxt = PH_TRAIL;
      end
    end

    res.swclk_pulse = clk_p;
    res.swdio_out   = dout;
    res.swdio_drive = drv;
    res.busy_res    = busy;
    res.done_res    = done;
    res.ack         = ack_nxt;
    res.read_data   = rx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cnt_r    <= 8'd0;
      shift_r  <= 33'd0;
      ack_r    <= 3'd0;
      rx_r     <= 32'd0;
      req_wr_r <= 1'b0;
      hdr_r    <= 8'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      shift_r  <= shift_nxt;
      ack_r    <= ack_nxt;
      rx_r     <= rx_nxt;
      req_wr_r <= req_wr_nxt;
      hdr_r    <= hdr_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/swdh_checker.sv
// ----------------------------------------------------------------------------
// swdh_checker
// Port-level checks of the serial wire debug host packet engine.
// ----------------------------------------------------------------------------
`default_nettype none

module swdh_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [swdh_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic                             out_tlast
);

  // a held output item keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // input only back-pressured by a stalled full output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output stall");

  // reset empties both stages
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  // idle periods have no clock, no busy and no end of sequence
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> !out_tdata[3] && !out_tlast)
    else $error("idle item marked busy or done");

endmodule

bind swd_host_packet_engine swdh_checker u_swdh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives bit periods into the serial wire debug host packet engine and checks
// every result item against a period-by-period model of the link sequencer.
// Directed read, write and line reset sequences with extreme register values
// come first. Random packets, line resets and stray commands follow, under
// four phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         LINE_LOW    = 0;
  localparam int         LINE_HIGH   = 1;
  localparam int         LINE_RAND   = 2;
  localparam int         CYCLE_LIMIT = 400000;

  typedef enum logic [3:0] {
    LK_IDLE, LK_HEADER, LK_TURN1, LK_ACK, LK_RDATA,
    LK_TURN2, LK_WDATA, LK_TRAIL, LK_RHIGH, LK_RLOW
  } link_phase_t;

  typedef struct packed {
    logic        swdio_in;
    logic [31:0] write_data;
    logic [1:0]  reg_addr;
    logic        ap_select;
    logic        is_write;
  } bit_item_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  // is_write, ap_select, reg_addr, write_data, swdio_in
  logic [swdh_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]                       in_tuser;   // command
  logic                             out_tvalid;
  logic                             out_tready;
  // swclk_pulse, swdio_out, swdio_drive, busy_res, ack, read_data
  logic [swdh_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tlast;  // done_res
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [swdh_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [7:0]                       cfg_data;

  // model state
  link_phase_t ph;
  logic [7:0]  cnt;
  logic [32:0] shreg;
  logic [2:0]  ack_q;
  logic [31:0] rdword;
  logic        req_wr;
  logic [7:0]  hdr;
  logic [7:0]  rh_q, ri_q, wi_q;

  swdh_pkg::out_item_t pending_periods[$];
  swdh_pkg::out_item_t want_r, got_r;

  int send_gap_pct;
  int stall_pct;
  int n_sent;
  int n_checked;
  int n_bad;
  int n_packets;
  int n_resets;
  int n_settings;
  int cycles;

  swd_host_packet_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  function automatic swdh_pkg::out_item_t advance_link(input logic [1:0] cmd,
                                                       input bit_item_t b);
    swdh_pkg::out_item_t r;
    logic                end_data;
    logic                rnw;
    logic [7:0]          trail;
    r             = '0;
    r.swclk_pulse = 1'b1;
    r.swdio_drive = 1'b1;
    r.busy_res    = 1'b1;
    end_data      = 1'b0;
    if (ph == LK_IDLE) begin
      if (cmd == swdh_pkg::CMD_START) begin
        rnw    = ~b.is_write;
        hdr    = {1'b1, 1'b0, ^{b.ap_select, rnw, b.reg_addr}, b.reg_addr, rnw, b.ap_select,
                  1'b1};
        req_wr = b.is_write;
        shreg  = b.is_write ? {^b.write_data, b.write_data} : 33'd0;
        ack_q  = 3'd0;
        cnt    = 8'd0;
        ph     = LK_HEADER;
      end else if (cmd == swdh_pkg::CMD_RESET) begin
        cnt = 8'd0;
        ph  = (rh_q == 8'd0) ? LK_RLOW : LK_RHIGH;
      end
    end
    trail = req_wr ? wi_q : ri_q;
    case (ph)
      LK_HEADER: begin
        r.swdio_out = hdr[cnt[2:0]];
        cnt = cnt + 8'd1;
        if (cnt >= swdh_pkg::HEADER_BITS) begin
          ph  = LK_TURN1;
          cnt = 8'd0;
        end
      end
      LK_TURN1: begin
        r.swdio_drive = 1'b0;
        ph  = LK_ACK;
        cnt = 8'd0;
      end
      LK_ACK: begin
        r.swdio_drive = 1'b0;
        ack_q = {b.swdio_in, ack_q[2:1]};
        cnt   = cnt + 8'd1;
        if (cnt >= swdh_pkg::ACK_BITS_N) begin
          cnt = 8'd0;
          ph  = req_wr ? LK_TURN2 : LK_RDATA;
        end
      end
      LK_RDATA: begin
        r.swdio_drive = 1'b0;
        shreg = {b.swdio_in, shreg[32:1]};
        cnt   = cnt + 8'd1;
        if (cnt >= swdh_pkg::DATA_BITS) begin
          rdword   = shreg[31:0];
          end_data = 1'b1;
        end
      end
      LK_TURN2: begin
        r.swdio_drive = 1'b0;
        ph  = LK_WDATA;
        cnt = 8'd0;
      end
      LK_WDATA: begin
        r.swdio_out = shreg[0];
        shreg = shreg >> 1;
        cnt   = cnt + 8'd1;
        if (cnt >= swdh_pkg::DATA_BITS) end_data = 1'b1;
      end
      LK_TRAIL: begin
        cnt = cnt + 8'd1;
        if (cnt >= trail) begin
          r.done_res = 1'b1;
          ph  = LK_IDLE;
          cnt = 8'd0;
        end
      end
      LK_RHIGH: begin
        r.swdio_out = 1'b1;
        cnt = cnt + 8'd1;
        if (cnt >= rh_q) begin
          ph  = LK_RLOW;
          cnt = 8'd0;
        end
      end
      LK_RLOW: begin
        cnt = cnt + 8'd1;
        if (cnt >= swdh_pkg::RESET_LOW) begin
          r.done_res = 1'b1;
          ph  = LK_IDLE;
          cnt = 8'd0;
        end
      end
      default: begin
        ph            = LK_IDLE;
        r.swclk_pulse = 1'b0;
        r.busy_res    = 1'b0;
        cnt           = 8'd0;
      end
    endcase
    if (end_data) begin
      cnt = 8'd0;
      if (trail == 8'd0) begin
        r.done_res = 1'b1;
        ph = LK_IDLE;
      end else begin
        ph = LK_TRAIL;
      end
    end
    r.ack       = ack_q;
    r.read_data = rdword;
    return r;
  endfunction

  task automatic send_bit(input logic [1:0] cmd, input bit_item_t b);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(swdh_pkg::IN_TDATA_W - $bits(bit_item_t)){1'b0}}, b};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    pending_periods.push_back(advance_link(cmd, b));
    n_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_periods.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one command, then ticks or noise commands on line_mode until idle
  task automatic run_sequence(input logic [1:0] cmd, input logic wr, input logic ap,
                              input logic [1:0] addr, input logic [31:0] wdata,
                              input int line_mode, input int noise_pct);
    bit_item_t  b;
    logic [1:0] c;
    b.is_write   = wr;
    b.ap_select  = ap;
    b.reg_addr   = addr;
    b.write_data = wdata;
    b.swdio_in   = (line_mode == LINE_RAND) ? 1'($urandom_range(1)) : line_mode[0];
    if (cmd == swdh_pkg::CMD_START) n_packets++;
    if (cmd == swdh_pkg::CMD_RESET) n_resets++;
    send_bit(cmd, b);
    while (ph != LK_IDLE) begin
      c            = ($urandom_range(99) < noise_pct) ? 2'($urandom_range(3))
                                                      : swdh_pkg::CMD_TICK;
      b.is_write   = 1'($urandom_range(1));
      b.ap_select  = 1'($urandom_range(1));
      b.reg_addr   = 2'($urandom_range(3));
      b.write_data = $urandom;
      b.swdio_in   = (line_mode == LINE_RAND) ? 1'($urandom_range(1)) : line_mode[0];
      send_bit(c, b);
    end
  endtask

  task automatic load_settings(input logic [7:0] rh, input logic [7:0] ri,
                               input logic [7:0] wi);
    logic [swdh_pkg::CFG_IDX_W-1:0] idx [3];
    logic [7:0]                     val [3];
    idx = '{swdh_pkg::REG_RESET_HIGH, swdh_pkg::REG_READ_IDLE, swdh_pkg::REG_WRITE_IDLE};
    val = '{rh, ri, wi};
    while (ph != LK_IDLE)
      run_sequence(swdh_pkg::CMD_TICK, 1'b0, 1'b0, 2'd0, 32'd0, LINE_RAND, 0);
    drain();
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    rh_q = rh;
    ri_q = ri;
    wi_q = wi;
    n_settings++;
  endtask

  task automatic report_bad(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    n_bad++;
    if (n_bad <= 10)
      $display("mismatch on %s at result %0d: expected %h, got %h", what, n_checked, want,
               got);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_periods.size() == 0) begin
        report_bad("unexpected item", 32'd0, out_tdata[31:0]);
      end else begin
        want_r = pending_periods.pop_front();
        got_r.swclk_pulse = out_tdata[0];
        got_r.swdio_out   = out_tdata[1];
        got_r.swdio_drive = out_tdata[2];
        got_r.busy_res    = out_tdata[3];
        got_r.done_res    = out_tlast;
        got_r.ack         = out_tdata[6:4];
        got_r.read_data   = out_tdata[38:7];
        if (got_r.swclk_pulse !== want_r.swclk_pulse)
          report_bad("swclk_pulse", 32'(want_r.swclk_pulse), 32'(got_r.swclk_pulse));
        if (got_r.swdio_out !== want_r.swdio_out)
          report_bad("swdio_out", 32'(want_r.swdio_out), 32'(got_r.swdio_out));
        if (got_r.swdio_drive !== want_r.swdio_drive)
          report_bad("swdio_drive", 32'(want_r.swdio_drive), 32'(got_r.swdio_drive));
        if (got_r.busy_res !== want_r.busy_res)
          report_bad("busy_res", 32'(want_r.busy_res), 32'(got_r.busy_res));
        if (got_r.done_res !== want_r.done_res)
          report_bad("done_res", 32'(want_r.done_res), 32'(got_r.done_res));
        if (got_r.ack !== want_r.ack)
          report_bad("ack", 32'(want_r.ack), 32'(got_r.ack));
        if (got_r.read_data !== want_r.read_data)
          report_bad("read_data", want_r.read_data, got_r.read_data);
      end
      n_checked++;
    end
  end

  task automatic test_reset_settings();
    run_sequence(swdh_pkg::CMD_START, 1'b0, 1'b0, 2'd0, 32'd0, LINE_LOW, 0);
    run_sequence(swdh_pkg::CMD_START, 1'b1, 1'b1, 2'd3, 32'hFFFF_FFFF, LINE_HIGH, 0);
    run_sequence(swdh_pkg::CMD_START, 1'b0, 1'b1, 2'd2, 32'd0, LINE_HIGH, 0);
    run_sequence(swdh_pkg::CMD_RESET, 1'b0, 1'b0, 2'd0, 32'd0, LINE_LOW, 0);
    run_sequence(CMD_SPARE, 1'b1, 1'b1, 2'd1, 32'hA5A5_5A5A, LINE_HIGH, 0);
    run_sequence(swdh_pkg::CMD_TICK, 1'b0, 1'b0, 2'd0, 32'd0, LINE_LOW, 0);
  endtask

  // stray commands while a packet or a line reset is under way
  task automatic test_busy_commands();
    run_sequence(swdh_pkg::CMD_START, 1'b1, 1'b0, 2'd1, $urandom, LINE_RAND, 100);
    run_sequence(swdh_pkg::CMD_START, 1'b0, 1'b0, 2'd2, 32'd0, LINE_RAND, 100);
    run_sequence(swdh_pkg::CMD_RESET, 1'b0, 1'b0, 2'd0, 32'd0, LINE_RAND, 100);
  endtask

  task automatic test_short_counts();
    load_settings(8'd0, 8'd0, 8'd0);
    run_sequence(swdh_pkg::CMD_RESET, 1'b0, 1'b0, 2'd0, 32'd0, LINE_RAND, 0);
    run_sequence(swdh_pkg::CMD_START, 1'b0, 1'b1, 2'd1, 32'd0, LINE_RAND, 0);
    run_sequence(swdh_pkg::CMD_START, 1'b1, 1'b0, 2'd0, 32'd0, LINE_RAND, 0);
    load_settings(8'd1, 8'd1, 8'd1);
    run_sequence(swdh_pkg::CMD_RESET, 1'b0, 1'b0, 2'd0, 32'd0, LINE_RAND, 0);
    run_sequence(swdh_pkg::CMD_START, 1'b1, 1'b1, 2'd2, 32'h8000_0001, LINE_RAND, 0);
  endtask

  task automatic test_long_counts();
    load_settings(8'd255, 8'd255, 8'd255);
    run_sequence(swdh_pkg::CMD_RESET, 1'b0, 1'b0, 2'd0, 32'd0, LINE_RAND, 0);
    run_sequence(swdh_pkg::CMD_START, 1'b1, 1'b1, 2'd1, $urandom, LINE_RAND, 0);
  endtask

  task automatic test_random_traffic(input int n_items, input int gap_pct, input int stalls,
                                     input logic [7:0] rh, input logic [7:0] ri,
                                     input logic [7:0] wi);
    int first;
    int pick;
    bit paused;
    load_settings(rh, ri, wi);
    send_gap_pct = gap_pct;
    stall_pct    = stalls;
    first        = n_sent;
    paused       = 1'b0;
    while (n_sent - first < n_items) begin
      pick = $urandom_range(99);
      if (!paused && n_sent - first >= n_items / 2) begin
        paused = 1'b1;
        drain();
      end
      if (pick < 70)
        run_sequence(swdh_pkg::CMD_START, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     2'($urandom_range(3)), $urandom, LINE_RAND, 10);
      else if (pick < 85)
        run_sequence(swdh_pkg::CMD_RESET, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     2'($urandom_range(3)), $urandom, LINE_RAND, 10);
      else
        run_sequence((pick < 95) ? swdh_pkg::CMD_TICK : CMD_SPARE, 1'($urandom_range(1)),
                     1'($urandom_range(1)), 2'($urandom_range(3)), $urandom, LINE_RAND, 0);
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = swdh_pkg::CMD_TICK;
    out_tready   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = swdh_pkg::REG_RESET_HIGH;
    cfg_data     = 8'd0;
    send_gap_pct = 0;
    stall_pct    = 0;
    n_sent       = 0;
    n_checked    = 0;
    n_bad        = 0;
    n_packets    = 0;
    n_resets     = 0;
    n_settings   = 0;
    cycles       = 0;
    ph           = LK_IDLE;
    cnt          = 8'd0;
    shreg        = 33'd0;
    ack_q        = 3'd0;
    rdword       = 32'd0;
    req_wr       = 1'b0;
    hdr          = 8'd0;
    rh_q         = swdh_pkg::RESET_HIGH_DEF;
    ri_q         = swdh_pkg::READ_IDLE_DEF;
    wi_q         = swdh_pkg::WRITE_IDLE_DEF;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_settings();
    test_busy_commands();
    test_short_counts();
    test_long_counts();
    test_random_traffic(120, 0, 0, 8'd50, 8'd0, 8'd1);
    test_random_traffic(120, 54, 0, swdh_pkg::RESET_HIGH_DEF, swdh_pkg::READ_IDLE_DEF,
                        swdh_pkg::WRITE_IDLE_DEF);
    test_random_traffic(120, 0, 54, 8'($urandom_range(50, 255)), 8'($urandom_range(0, 15)),
                        8'($urandom_range(0, 15)));
    test_random_traffic(120, 18, 18, 8'($urandom_range(50, 255)), 8'($urandom_range(0, 40)),
                        8'($urandom_range(0, 40)));

    send_gap_pct = 0;
    stall_pct    = 0;
    drain();
    repeat (20) @(posedge clk);
    if (pending_periods.size() != 0)
      report_bad("missing items", 32'd0, pending_periods.size());
    $display("%0d bit periods checked over %0d packets and %0d line resets", n_checked,
             n_packets, n_resets);
    $display("%0d register settings, %0d failures", n_settings, n_bad);
    if (n_bad == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
